/* hdl/pfsp_pkg.sv */
package pfsp_pkg;

	// Result kinds, carried on m_axis_tuser
	localparam logic [1:0] KIND_FRAME  = 2'd0;
	localparam logic [1:0] KIND_TOTALS = 2'd1;
	localparam logic [1:0] KIND_UNSUP  = 2'd2;

	// File format codes
	localparam logic [2:0] FMT_8SVX = 3'd0;
	localparam logic [2:0] FMT_AIFF = 3'd1;
	localparam logic [2:0] FMT_S16  = 3'd3;
	localparam logic [2:0] FMT_WAVE = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_HIFI   = 2'd1;
	localparam logic [1:0] REG_STEREO = 2'd2;

	// Input command codes
	localparam logic CMD_FRAME  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// Volume hint divider: 22-bit constant dividend, one quotient bit per step
	localparam int          VOL_W        = 22;
	localparam logic [VOL_W-1:0] VOLUME_SCALE = 22'd3276800;
	localparam int          DIV_CNT_W    = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd21;

	// Controller to datapath commands
	typedef struct packed {
		logic frame;     // pack a sample frame, update peak and totals
		logic unsup;     // answer unsupported stereo 8SVX
		logic finish;    // latch totals, clear state, start divider
		logic div_step;  // one restoring division step
		logic report;    // load totals result (last division step)
	} pfsp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic unsupported;
	} pfsp_status_t;

endpackage

/* hdl/pfsp_ctrl.sv */
module pfsp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_command,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  pfsp_pkg::pfsp_status_t status,
	output pfsp_pkg::pfsp_cmd_t    cmd
);
	import pfsp_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t               state_q;
	logic                 out_valid_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 in_fire;
	logic                 out_fire;
	logic                 load;

	// Output slot is free when empty or being drained this cycle
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd.unsup    = in_fire && status.unsupported;
		cmd.frame    = in_fire && !status.unsupported && (in_command == CMD_FRAME);
		cmd.finish   = in_fire && !status.unsupported && (in_command == CMD_FINISH);
		cmd.div_step = (state_q == ST_DIV);
		cmd.report   = (state_q == ST_DIV) && (cnt_q == DIV_LAST);
	end

	assign load = cmd.unsup || cmd.frame || cmd.report;

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_fire)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.finish)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_LAST)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/pfsp_datapath.sv */
module pfsp_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfsp_pkg::pfsp_cmd_t    cmd,
	output pfsp_pkg::pfsp_status_t status,
	input  logic                   cfg_write,
	input  logic [1:0]             cfg_index,
	input  logic [2:0]             cfg_data,
	input  logic [31:0]            first_sample,
	input  logic [31:0]            second_sample,
	output logic [1:0]             result_kind,
	output logic [15:0]            first_word,
	output logic [15:0]            second_word,
	output logic                   split_to_second_file,
	output logic [31:0]            byte_total,
	output logic [31:0]            frame_total,
	output logic                   pad_needed,
	output logic [30:0]            peak_level,
	output logic [21:0]            volume_hint
);
	import pfsp_pkg::*;

	// Magnitude of a sample; hifi saturates -2^31 to 2^31-1
	function automatic logic [30:0] sample_mag(input logic [31:0] s, input logic hifi);
		logic [31:0] n;
		logic [30:0] m;
		n = 32'd0 - s;
		if (hifi) begin
			if (!s[31])
				m = s[30:0];
			else if (n[31])
				m = 31'h7fffffff;
			else
				m = n[30:0];
		end else begin
			if (s[15])
				n = 32'h0001_0000 - {16'd0, s[15:0]};
			else
				n = {16'd0, s[15:0]};
			m = n[30:0];
		end
		return m;
	endfunction

	// Pack a sample in file byte order
	function automatic logic [15:0] pack_sample(input logic [31:0] s, input logic hifi,
		input logic [2:0] fmt);
		logic [15:0] w;
		if (fmt == FMT_8SVX) begin
			w = hifi ? {8'd0, s[31:24]} : {8'd0, s[15:8]};
		end else begin
			w = hifi ? s[31:16] : s[15:0];
			if (fmt == FMT_WAVE)
				w = {w[7:0], w[15:8]};
		end
		return w;
	endfunction

	logic [2:0]       fmt_q;
	logic             hifi_q;
	logic             stereo_q;

	logic [30:0]      peak_q;
	logic [31:0]      bytes_q;
	logic [31:0]      frames_q;

	logic [31:0]      fin_bytes_q;
	logic [31:0]      fin_frames_q;
	logic             fin_pad_q;
	logic [30:0]      fin_peak_q;

	logic [VOL_W-1:0] dvd_q;
	logic [VOL_W-1:0] rem_q;
	logic [VOL_W-1:0] quo_q;

	logic [1:0]       kind_q;
	logic [15:0]      fw_q;
	logic [15:0]      sw_q;
	logic             split_q;
	logic [31:0]      byte_out_q;
	logic [31:0]      frame_out_q;
	logic             pad_q;
	logic [30:0]      peak_out_q;
	logic [VOL_W-1:0] vol_q;

	logic [30:0]      mag1;
	logic [30:0]      mag2;
	logic [30:0]      peak_a;
	logic [30:0]      peak_next;
	logic [31:0]      byte_inc;
	logic [30:0]      peak_scaled;
	logic [VOL_W:0]   trial;
	logic             qbit;
	logic [VOL_W-1:0] quo_next;

	assign status.unsupported = (fmt_q == FMT_8SVX) && stereo_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_AIFF;
			hifi_q   <= 1'b0;
			stereo_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FORMAT: fmt_q    <= cfg_data;
				REG_HIFI:   hifi_q   <= cfg_data[0];
				REG_STEREO: stereo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Peak tracking and per-file byte count
	always_comb begin
		mag1   = sample_mag(first_sample, hifi_q);
		mag2   = sample_mag(second_sample, hifi_q);
		peak_a = (mag1 > peak_q) ? mag1 : peak_q;
		if (stereo_q && (mag2 > peak_a))
			peak_next = mag2;
		else
			peak_next = peak_a;
		if (fmt_q == FMT_8SVX)
			byte_inc = 32'd1;
		else if (stereo_q && (fmt_q != FMT_S16))
			byte_inc = 32'd4;
		else
			byte_inc = 32'd2;
		peak_scaled = hifi_q ? {16'd0, peak_q[30:16]} : peak_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q   <= '0;
			bytes_q  <= '0;
			frames_q <= '0;
		end else if (cmd.finish) begin
			peak_q   <= '0;
			bytes_q  <= '0;
			frames_q <= '0;
		end else if (cmd.frame) begin
			peak_q   <= peak_next;
			bytes_q  <= bytes_q + byte_inc;
			frames_q <= frames_q + 32'd1;
		end
	end

	// Restoring divider: VOLUME_SCALE / peak, one bit per step
	always_comb begin
		trial    = {rem_q, dvd_q[VOL_W-1]};
		qbit     = ({9'd0, trial} >= {1'b0, fin_peak_q});
		quo_next = {quo_q[VOL_W-2:0], qbit};
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			fin_bytes_q  <= bytes_q;
			fin_frames_q <= frames_q;
			fin_pad_q    <= (fmt_q == FMT_8SVX) && bytes_q[0];
			fin_peak_q   <= peak_scaled;
			dvd_q        <= VOLUME_SCALE;
			rem_q        <= '0;
			quo_q        <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[VOL_W-2:0], 1'b0};
			quo_q <= quo_next;
			if (qbit)
				rem_q <= trial[VOL_W-1:0] - fin_peak_q[VOL_W-1:0];
			else
				rem_q <= trial[VOL_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.frame) begin
			kind_q      <= KIND_FRAME;
			fw_q        <= pack_sample(first_sample, hifi_q, fmt_q);
			sw_q        <= stereo_q ? pack_sample(second_sample, hifi_q, fmt_q) : 16'd0;
			split_q     <= stereo_q && (fmt_q == FMT_S16);
			byte_out_q  <= '0;
			frame_out_q <= '0;
			pad_q       <= 1'b0;
			peak_out_q  <= '0;
			vol_q       <= '0;
		end else if (cmd.unsup) begin
			kind_q      <= KIND_UNSUP;
			fw_q        <= '0;
			sw_q        <= '0;
			split_q     <= 1'b0;
			byte_out_q  <= '0;
			frame_out_q <= '0;
			pad_q       <= 1'b0;
			peak_out_q  <= '0;
			vol_q       <= '0;
		end else if (cmd.report) begin
			kind_q      <= KIND_TOTALS;
			fw_q        <= '0;
			sw_q        <= '0;
			split_q     <= 1'b0;
			byte_out_q  <= fin_bytes_q;
			frame_out_q <= fin_frames_q;
			pad_q       <= fin_pad_q;
			peak_out_q  <= fin_peak_q;
			vol_q       <= (fin_peak_q == '0) ? '0 : quo_next;
		end
	end

	assign result_kind          = kind_q;
	assign first_word           = fw_q;
	assign second_word          = sw_q;
	assign split_to_second_file = split_q;
	assign byte_total           = byte_out_q;
	assign frame_total          = frame_out_q;
	assign pad_needed           = pad_q;
	assign peak_level           = peak_out_q;
	assign volume_hint          = vol_q;

endmodule

/* hdl/pcm_file_sample_packer.sv */
// PCM sample packer with peak meter.
// Input stream s_axis: one audio frame or a finish request per item; tuser
// carries the command, tdata the first (mono/left) and second (right) sample.
// Output stream m_axis: one result per input item; tuser carries the kind
// (packed frame, totals, unsupported stereo 8SVX), tdata the packed words,
// totals, pad flag, peak level and volume hint.
// Config channel cfg_*: index 0 file format, 1 hifi, 2 stereo; always ready.
// Write it only while the block is idle.
// A sample frame is loaded into the output register at the edge that takes it
// and can leave in the following cycle; frames are taken one per cycle while
// the output drains.
// A finish item runs 22 steps of the restoring divider that forms
// 3276800 / peak, one quotient bit per cycle; the last step loads the result
// into the output register.
// No input is taken while the divider runs.
// When the receiver stalls, the result holds in the output register and the
// input stalls once that register is full and not being read.
// Reset clears peak, totals and pending results and restores the format
// registers to AIFF, 16-bit, mono.
module pcm_file_sample_packer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // first_sample[31:0], second_sample[63:32]
	input  logic [0:0]   s_axis_tuser,   // command[0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// first_word[15:0], second_word[31:16], split_to_second_file[32],
	// byte_total[64:33], frame_total[96:65], pad_needed[97],
	// peak_level[128:98], volume_hint[150:129], zero[151]
	output logic [151:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // result_kind[1:0]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [2:0]   cfg_data
);
	import pfsp_pkg::*;

	pfsp_cmd_t    cmd;
	pfsp_status_t status;
	logic [15:0]  first_word;
	logic [15:0]  second_word;
	logic         split_to_second_file;
	logic [31:0]  byte_total;
	logic [31:0]  frame_total;
	logic         pad_needed;
	logic [30:0]  peak_level;
	logic [21:0]  volume_hint;

	assign cfg_ready = 1'b1;

	pfsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_command (s_axis_tuser[0]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.status     (status),
		.cmd        (cmd)
	);

	pfsp_datapath u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.cfg_write            (cfg_valid && cfg_ready),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.first_sample         (s_axis_tdata[31:0]),
		.second_sample        (s_axis_tdata[63:32]),
		.result_kind          (m_axis_tuser),
		.first_word           (first_word),
		.second_word          (second_word),
		.split_to_second_file (split_to_second_file),
		.byte_total           (byte_total),
		.frame_total          (frame_total),
		.pad_needed           (pad_needed),
		.peak_level           (peak_level),
		.volume_hint          (volume_hint)
	);

	// Result payload, highest field first
	assign m_axis_tdata = {1'b0, volume_hint, peak_level, pad_needed, frame_total,
		byte_total, split_to_second_file, second_word, first_word};

endmodule

/* bench/tb_pcm_file_sample_packer.sv */
module tb_pcm_file_sample_packer;
	timeunit 1ns;
	timeprecision 1ps;

	import pfsp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 30;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata;
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [151:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [2:0]   cfg_data;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int settings_made;
	int cycles;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] first_word;
		logic [15:0] second_word;
		logic        split;
		logic [31:0] byte_total;
		logic [31:0] frame_total;
		logic        pad;
		logic [30:0] peak;
		logic [21:0] vol;
	} packer_result_t;

	// Packing and metering predictor plus the queue of results still owed
	class packer_board;
		logic [2:0]  fmt;
		logic        hifi;
		logic        stereo;
		logic [31:0] peak;
		logic [31:0] bytes;
		logic [31:0] frames;
		packer_result_t owed[$];
		int errors;
		int checked;
		int totals_seen;
		int unsup_seen;

		function new();
			fmt = FMT_AIFF;
			hifi = 1'b0;
			stereo = 1'b0;
			peak = '0;
			bytes = '0;
			frames = '0;
			errors = 0;
			checked = 0;
			totals_seen = 0;
			unsup_seen = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [2:0] val);
			case (idx)
				REG_FORMAT: fmt = val;
				REG_HIFI: hifi = val[0];
				REG_STEREO: stereo = val[0];
				default: ;
			endcase
		endfunction

		// absolute value; hifi -2^31 saturates, 16-bit mode uses low half only
		function logic [31:0] magnitude(logic [31:0] s);
			logic [31:0] u;
			if (hifi) begin
				u = s;
				if (u[31]) begin
					u = -u;
					if (u[31])
						u = 32'h7fff_ffff;
				end
			end else begin
				u = {16'h0, s[15:0]};
				if (u[15])
					u = 32'h1_0000 - u;
			end
			return u;
		endfunction

		function logic [15:0] pack_word(logic [31:0] s);
			logic [15:0] w;
			if (fmt == FMT_8SVX)
				return {8'h00, hifi ? s[31:24] : s[15:8]};
			w = hifi ? s[31:16] : s[15:0];
			if (fmt == FMT_WAVE)
				w = {w[7:0], w[15:8]};
			return w;
		endfunction

		function void note_item(logic cmd, logic [31:0] a, logic [31:0] b);
			packer_result_t r;
			logic [31:0] lvl;
			r = '0;
			if (fmt == FMT_8SVX && stereo) begin
				r.kind = KIND_UNSUP;
				unsup_seen++;
			end else if (cmd == CMD_FINISH) begin
				lvl = hifi ? (peak >> 16) : peak;
				r.kind = KIND_TOTALS;
				r.byte_total = bytes;
				r.frame_total = frames;
				r.pad = (fmt == FMT_8SVX) && bytes[0];
				r.peak = lvl[30:0];
				r.vol = (lvl != 0) ? 22'(32'(VOLUME_SCALE) / lvl) : '0;
				peak = '0;
				bytes = '0;
				frames = '0;
				totals_seen++;
			end else begin
				if (magnitude(a) > peak)
					peak = magnitude(a);
				if (stereo && magnitude(b) > peak)
					peak = magnitude(b);
				r.kind = KIND_FRAME;
				r.first_word = pack_word(a);
				if (stereo) begin
					r.second_word = pack_word(b);
					r.split = (fmt == FMT_S16);
				end
				// S16 stereo counts one channel file only
				bytes += ((fmt == FMT_8SVX) ? 32'd1 : 32'd2)
					* ((stereo && fmt != FMT_S16) ? 32'd2 : 32'd1);
				frames++;
			end
			owed.push_back(r);
		endfunction

		function void flag(string what, logic [31:0] e, logic [31:0] a);
			errors++;
			if (errors <= 10)
				$display("mismatch in %s: expected 0x%0h, got 0x%0h", what, e, a);
		endfunction

		function void check_result(logic [1:0] kind, logic [151:0] d);
			packer_result_t e;
			if (owed.size() == 0) begin
				flag("unexpected result kind", '0, kind);
				return;
			end
			e = owed.pop_front();
			checked++;
			if (kind != e.kind) flag("result_kind", e.kind, kind);
			if (d[15:0] != e.first_word) flag("first_word", e.first_word, d[15:0]);
			if (d[31:16] != e.second_word) flag("second_word", e.second_word, d[31:16]);
			if (d[32] != e.split) flag("split_to_second_file", e.split, d[32]);
			if (d[64:33] != e.byte_total) flag("byte_total", e.byte_total, d[64:33]);
			if (d[96:65] != e.frame_total) flag("frame_total", e.frame_total, d[96:65]);
			if (d[97] != e.pad) flag("pad_needed", e.pad, d[97]);
			if (d[128:98] != e.peak) flag("peak_level", e.peak, d[128:98]);
			if (d[150:129] != e.vol) flag("volume_hint", e.vol, d[150:129]);
			if (d[151] != 1'b0) flag("tdata fill bit", '0, d[151]);
		endfunction
	endclass

	packer_board board;

	pcm_file_sample_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver stalls
	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tuser, m_axis_tdata);
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("pcm_file_sample_packer test failed");
			$finish;
		end
	end

	// one item on s_axis; valid stays high for a back-to-back follower
	task automatic send_item(logic cmd, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = cmd;
		s_axis_tdata = {b, a};
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_item(cmd, a, b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (board.owed.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [2:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// upper data bits of the one-bit registers are don't-care, so scramble them
	task automatic configure(logic [2:0] fmt, logic hifi, logic stereo);
		wait_idle();
		write_reg(REG_FORMAT, fmt);
		write_reg(REG_HIFI, {2'($urandom), hifi});
		write_reg(REG_STEREO, {2'($urandom), stereo});
		settings_made++;
	endtask

	// sample of a given amplitude width, with the odd full-scale value
	function automatic logic [31:0] rand_sample(int width, logic hifi);
		logic [31:0] s;
		case ($urandom_range(19))
			0: s = 32'h8000_0000;
			1: s = 32'h7fff_ffff;
			2: s = {16'($urandom), 16'h8000};
			3: s = '0;
			default: begin
				s = $urandom;
				if (width < 32)
					s = 32'($signed(s << (32 - width)) >>> (32 - width));
				if (!hifi && $urandom_range(1))
					s[31:16] = 16'($urandom);
			end
		endcase
		return s;
	endfunction

	task automatic run_phase(int s_pct, int r_pct, int count);
		int done;
		int n;
		int width;
		logic hifi;
		done = 0;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		while (done < count) begin
			hifi = 1'($urandom);
			configure(3'($urandom_range(7)), hifi, 1'($urandom));
			width = hifi ? $urandom_range(1, 32) : $urandom_range(1, 16);
			n = $urandom_range(20, 70);
			repeat (n) begin
				if ($urandom_range(24) == 0)
					send_item(CMD_FINISH, $urandom, $urandom);
				else
					send_item(CMD_FRAME, rand_sample(width, hifi), rand_sample(width, hifi));
			end
			send_item(CMD_FINISH, $urandom, $urandom);
			done += n + 1;
		end
	endtask

	initial begin
		board = new();
		cycles = 0;
		items_sent = 0;
		settings_made = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_FRAME;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FORMAT;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset setting: 16-bit mono AIFF, junk in the unused upper half
		send_item(CMD_FRAME, 32'h0000_7fff, 32'hdead_beef);
		send_item(CMD_FRAME, 32'h1234_8000, 32'h0);
		send_item(CMD_FRAME, 32'hffff_0001, 32'hffff_ffff);
		send_item(CMD_FINISH, 32'h0, 32'h0);

		// hifi stereo WAVE, full-scale negative saturates
		configure(FMT_WAVE, 1'b1, 1'b1);
		send_item(CMD_FRAME, 32'h8000_0000, 32'h7fff_ffff);
		send_item(CMD_FRAME, 32'h0, 32'hffff_ffff);
		send_item(CMD_FINISH, 32'h0, 32'h0);

		// S16 stereo goes to two files
		configure(FMT_S16, 1'b0, 1'b1);
		send_item(CMD_FRAME, 32'h1234_abcd, 32'h5678_ef01);
		send_item(CMD_FINISH, 32'h0, 32'h0);

		// 8SVX mono with an odd byte total
		configure(FMT_8SVX, 1'b0, 1'b0);
		send_item(CMD_FRAME, 32'h0000_8000, 32'h0);
		send_item(CMD_FRAME, 32'h0000_7f80, 32'h0);
		send_item(CMD_FRAME, 32'h0000_0001, 32'h0);
		send_item(CMD_FINISH, 32'h0, 32'h0);

		// stereo 8SVX is refused
		configure(FMT_8SVX, 1'b1, 1'b1);
		send_item(CMD_FRAME, 32'h7fff_ffff, 32'h8000_0000);
		send_item(CMD_FINISH, 32'h0, 32'h0);

		// unused format codes act as AIFF; finish with zero peak
		configure(3'd5, 1'b1, 1'b0);
		send_item(CMD_FINISH, 32'hffff_ffff, 32'hffff_ffff);
		configure(3'd7, 1'b0, 1'b0);
		send_item(CMD_FRAME, 32'h0000_0003, 32'h0);
		send_item(CMD_FINISH, 32'h0, 32'h0);

		run_phase(19, 85, 650);
		run_phase(85, 19, 650);
		run_phase(0, 0, 650);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d items sent over %0d register settings; %0d results checked",
			items_sent, settings_made, board.checked);
		$display("%0d totals reports, %0d unsupported answers, %0d mismatches",
			board.totals_seen, board.unsup_seen, board.errors);
		if (board.errors == 0)
			$display("pcm_file_sample_packer test passed");
		else
			$display("pcm_file_sample_packer test failed");
		$finish;
	end

endmodule
